// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the controller request block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crfrc_pkg.sv -----
// Package for the controller request frame and reply check block.
// Codes, frame constants and the structs passed between modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crfrc_pkg;

    // input operation codes (tuser)
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic [2:0] REG_KIND_PARAM = 3'd0;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // reply status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;

    localparam logic [7:0] CMD_READ     = 8'h52;
    localparam logic [7:0] CMD_WRITE    = 8'h43;
    localparam logic [7:0] STATION_FLAG = 8'h80;
    localparam logic [3:0] MIN_REPLY    = 4'd10;
    localparam logic [3:0] WORD_BYTES   = 4'd8;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // control from the top level to the reply checker
    typedef struct packed {
        logic       req_take;   // request finished: keep station, clear reply
        logic       byte_take;  // reply byte consumed
        logic [6:0] station;
        logic [7:0] rx_byte;
        logic       rx_last;
    } reply_ctrl_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0][15:0] words;   // [0] pv, [1] sv, [2] mv, [3] aux
    } reply_res_t;

endpackage

`default_nettype wire

// ----- rtl/crfrc_frame_gen.sv -----
// Request frame builder: checksum and byte selection, one frame byte per advance.
// Depends on crfrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crfrc_frame_gen import crfrc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [1:0]  op,
    input  wire logic [6:0]  station,
    input  wire logic [2:0]  reg_kind,
    input  wire logic [7:0]  param_code,
    input  wire logic [15:0] write_value,
    input  wire logic        advance,
    output logic [7:0]       tx_byte,
    output logic             frame_last
);

    logic [2:0]  byte_idx_reg;
    logic [2:0]  byte_idx_next;
    logic [7:0]  cmd;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] csum;
    logic [7:0]  st_byte;

    always_comb begin
        cmd     = (op == OP_READ) ? CMD_READ : CMD_WRITE;
        code    = (reg_kind == REG_KIND_PARAM) ? param_code : 8'h00;
        value   = (op == OP_READ) ? 16'h0000 : write_value;
        csum    = {code, 8'h00} + {8'h00, cmd} + {9'h000, station} + value;
        st_byte = {1'b0, station} + STATION_FLAG;
    end

    always_comb begin
        unique case (byte_idx_reg)
            3'd0:    tx_byte = st_byte;
            3'd1:    tx_byte = st_byte;
            3'd2:    tx_byte = cmd;
            3'd3:    tx_byte = code;
            3'd4:    tx_byte = value[7:0];
            3'd5:    tx_byte = value[15:8];
            3'd6:    tx_byte = csum[7:0];
            default: tx_byte = csum[15:8];
        endcase
    end

    assign frame_last    = (byte_idx_reg == 3'd7);
    // wraps to zero after the eighth byte
    assign byte_idx_next = advance ? byte_idx_reg + 3'd1 : byte_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg <= 3'd0;
        end else begin
            byte_idx_reg <= byte_idx_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/crfrc_reply_chk.sv -----
// Reply collector and checker: kept station, byte count, words and tail bytes.
// Depends on crfrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crfrc_reply_chk import crfrc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire reply_ctrl_t ctrl,
    output reply_res_t       res
);

    logic [6:0]       station_reg;
    logic [3:0]       count_reg;
    logic [3:0]       count_next;
    logic [3:0][15:0] words_reg;
    logic [3:0][15:0] words_next;
    logic [1:0][7:0]  tail_reg;
    logic [1:0][7:0]  tail_next;
    logic [15:0]      sum;
    logic [15:0]      got;
    logic             short_reply;

    always_comb begin
        words_next = words_reg;
        if (count_reg < WORD_BYTES) begin
            if (count_reg[0]) begin
                words_next[count_reg[2:1]][15:8] = ctrl.rx_byte;
            end else begin
                words_next[count_reg[2:1]][7:0] = ctrl.rx_byte;
            end
        end
        tail_next[0] = tail_reg[1];
        tail_next[1] = ctrl.rx_byte;
        count_next   = (count_reg < MIN_REPLY) ? count_reg + 4'd1 : count_reg;

        sum = words_next[0] + words_next[1] + words_next[2] + words_next[3]
            + {9'h000, station_reg};
        got = {tail_next[1], tail_next[0]};
        short_reply = (count_next < MIN_REPLY);

        if (short_reply) begin
            res.status = ST_SHORT;
            res.words  = '0;
        end else begin
            res.status = (sum == got) ? ST_OK : ST_BAD_SUM;
            res.words  = words_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_reg <= 7'd0;
            count_reg   <= 4'd0;
            words_reg   <= '0;
            tail_reg    <= '0;
        end else if (ctrl.req_take) begin
            station_reg <= ctrl.station;
            count_reg   <= 4'd0;
            words_reg   <= '0;
            tail_reg    <= '0;
        end else if (ctrl.byte_take) begin
            if (ctrl.rx_last) begin
                count_reg <= 4'd0;
                words_reg <= '0;
                tail_reg  <= '0;
            end else begin
                count_reg <= count_next;
                words_reg <= words_next;
                tail_reg  <= tail_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/controller_request_frame_and_reply_check.sv -----
// Controller request frame builder and reply checker, top level.
// Result items are registered in the output register. A reply byte leaves the input register
// as soon as the output slot is free. Throughput: a read/write request holds the input register
// until its eighth frame byte is loaded, one frame byte per cycle while the output slot is free.
// Reset: synchronous on aresetn low; clears valids, frame byte index, kept station
// and the reply collection.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module controller_request_frame_and_reply_check import crfrc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input item
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [6:0] station, [9:7] reg_kind, [17:10] param_code, [33:18] write_value,
    // [41:34] rx_byte, [47:42] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,  // [1:0] op
    input  wire logic                  s_axis_tlast,  // rx_last
    // result item
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] tx_byte, [9:8] status, [25:10] word_pv, [41:26] word_sv,
    // [57:42] word_mv, [73:58] word_aux, [79:74] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tuser,  // kind
    output logic                       m_axis_tlast   // last
);

    // ---- input register -------------------------------------------------
    logic        in_valid_reg;
    logic [1:0]  op_reg;
    logic [6:0]  station_reg;
    logic [2:0]  reg_kind_reg;
    logic [7:0]  param_code_reg;
    logic [15:0] write_value_reg;
    logic [7:0]  rx_byte_reg;
    logic        rx_last_reg;

    // ---- output register ------------------------------------------------
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_kind_reg;
    logic                  m_last_reg;

    logic        is_req;
    logic        is_reply;
    logic        out_free;
    logic        out_load;
    logic        in_consume;
    logic        s_take;
    logic [7:0]  tx_byte;
    logic        frame_last;
    reply_ctrl_t rctrl;
    reply_res_t  rres;
    logic [OUT_DATA_W-1:0] out_data;

    assign is_req   = (op_reg == OP_READ) || (op_reg == OP_WRITE);
    assign is_reply = (op_reg == OP_REPLY);

    // output slot free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    // a request leaves the input register only with its eighth byte;
    // reply bytes and the unused op leave at once
    assign in_consume = in_valid_reg && out_free && (!is_req || frame_last);
    assign out_load   = in_valid_reg && out_free && (is_req || (is_reply && rx_last_reg));

    assign s_axis_tready = !in_valid_reg || in_consume;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            op_reg          <= s_axis_tuser;
            station_reg     <= s_axis_tdata[6:0];
            reg_kind_reg    <= s_axis_tdata[9:7];
            param_code_reg  <= s_axis_tdata[17:10];
            write_value_reg <= s_axis_tdata[33:18];
            rx_byte_reg     <= s_axis_tdata[41:34];
            rx_last_reg     <= s_axis_tlast;
        end
    end

    // ---- frame builder --------------------------------------------------
    crfrc_frame_gen u_frame_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op_reg),
        .station     (station_reg),
        .reg_kind    (reg_kind_reg),
        .param_code  (param_code_reg),
        .write_value (write_value_reg),
        .advance     (out_load && is_req),
        .tx_byte     (tx_byte),
        .frame_last  (frame_last)
    );

    // ---- reply collector / checker --------------------------------------
    always_comb begin
        rctrl.req_take  = in_consume && is_req;
        rctrl.byte_take = in_consume && is_reply;
        rctrl.station   = station_reg;
        rctrl.rx_byte   = rx_byte_reg;
        rctrl.rx_last   = rx_last_reg;
    end

    crfrc_reply_chk u_reply_chk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rctrl),
        .res     (rres)
    );

    // ---- result packing -------------------------------------------------
    always_comb begin
        if (is_req) begin
            out_data = {{(OUT_DATA_W-8){1'b0}}, tx_byte};
        end else begin
            out_data = {6'd0, rres.words[3], rres.words[2], rres.words[1],
                        rres.words[0], rres.status, 8'h00};
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
            m_kind_reg <= is_req ? KIND_FRAME : KIND_REPLY;
            m_last_reg <= is_req ? frame_last : 1'b1;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

    // ---- checks ---------------------------------------------------------
    // a stalled input side always means an item is parked in the input register
    `ASSERT_IMPL(a_ready_low_holds_item, aclk, aresetn, !s_axis_tready, in_valid_reg, "input stalled with empty register")
    // a result is never dropped while the consumer stalls
    `ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid_reg && !m_axis_tready, m_valid_reg, "result lost under stall")
    // frame bytes carry no status or words
    `ASSERT_IMPL(a_frame_clean, aclk, aresetn, m_valid_reg && (m_kind_reg == KIND_FRAME), m_data_reg[OUT_DATA_W-1:8] == '0, "frame byte with status or words")
    // a short reply reports no words
    `ASSERT_IMPL(a_short_empty, aclk, aresetn, m_valid_reg && (m_kind_reg == KIND_REPLY) && (m_data_reg[9:8] == ST_SHORT), m_data_reg[73:10] == '0, "short reply with words")

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for controller_request_frame_and_reply_check.
// Needs crfrc_pkg and the block's RTL; predicts request frames and reply verdicts
// in its own model and checks every result item against it.
`timescale 1ns / 1ps

module testbench;
    import crfrc_pkg::*;

    // op code the block ignores, and register kinds beyond the parameter kind
    localparam logic [1:0] OP_SPARE        = 2'd3;
    localparam logic [2:0] REG_KIND_SV     = 3'd2;
    localparam logic [2:0] REG_KIND_UNUSED = 3'd7;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int REPORT_LIMIT    = 10;

    // one input item, unpacked
    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  station;
        logic [2:0]  reg_kind;
        logic [7:0]  code;
        logic [15:0] value;
        logic [7:0]  rx;
        logic        rx_last;
    } link_in_t;

    // one result item, unpacked; words[0] pv .. words[3] aux
    typedef struct packed {
        logic             kind;
        logic [7:0]       tx;
        logic             last;
        logic [1:0]       status;
        logic [3:0][15:0] words;
    } link_out_t;

    // directed row: expected result typed in only where it is obvious
    typedef struct {
        link_in_t  it;
        bit        typed;
        link_out_t want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    controller_request_frame_and_reply_check dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state: kept station and the reply being collected
    logic [6:0]       kept_station;
    logic [3:0]       rx_count;
    logic [3:0][15:0] rx_words;
    logic [1:0][7:0]  rx_tail;

    link_out_t frame_verdict_q[$];   // results still owed by the block
    link_out_t step_out[$];          // results of the latest accepted item
    stim_row_t stim_rows[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_off_req = 1'b0;
    int mismatches   = 0;
    int items_sent   = 0;
    logic [6:0] gen_station = '0;    // station the stimulus last requested

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_collection();
        rx_count = '0;
        rx_words = '0;
        rx_tail  = '0;
    endfunction

    // Works out the result items that one accepted input item causes.
    function automatic void build_frame_or_verdict(input link_in_t it);
        logic [7:0]       cmd;
        logic [7:0]       code;
        logic [15:0]      val;
        logic [15:0]      sum;
        logic [7:0]       frame [8];
        link_out_t        r;
        step_out.delete();
        case (it.op)
            OP_READ, OP_WRITE: begin
                cmd  = (it.op == OP_READ) ? CMD_READ : CMD_WRITE;
                // only the parameter kind carries a code
                code = (it.reg_kind == REG_KIND_PARAM) ? it.code : 8'd0;
                val  = (it.op == OP_READ) ? 16'd0 : it.value;
                sum  = {code, 8'd0} + {8'd0, cmd} + {9'd0, it.station} + val;
                frame[0] = STATION_FLAG | {1'b0, it.station};
                frame[1] = frame[0];
                frame[2] = cmd;
                frame[3] = code;
                frame[4] = val[7:0];
                frame[5] = val[15:8];
                frame[6] = sum[7:0];
                frame[7] = sum[15:8];
                kept_station = it.station;
                clear_collection();
                for (int i = 0; i < 8; i++) begin
                    r      = '0;
                    r.kind = KIND_FRAME;
                    r.tx   = frame[i];
                    r.last = (i == 7);
                    step_out.insert(step_out.size(), r);
                end
            end
            OP_REPLY: begin
                // bytes past the eighth never land in the words
                if (rx_count < WORD_BYTES) begin
                    if (rx_count[0])
                        rx_words[rx_count[2:1]][15:8] = it.rx;
                    else
                        rx_words[rx_count[2:1]][7:0] = it.rx;
                end
                rx_tail[0] = rx_tail[1];
                rx_tail[1] = it.rx;
                if (rx_count < MIN_REPLY)
                    rx_count = rx_count + 4'd1;
                if (it.rx_last) begin
                    r      = '0;
                    r.kind = KIND_REPLY;
                    r.last = 1'b1;
                    if (rx_count < MIN_REPLY) begin
                        r.status = ST_SHORT;
                    end else begin
                        sum = rx_words[0] + rx_words[1] + rx_words[2] + rx_words[3]
                            + {9'd0, kept_station};
                        r.status = (sum == {rx_tail[1], rx_tail[0]}) ? ST_OK : ST_BAD_SUM;
                        r.words  = rx_words;
                    end
                    step_out.insert(step_out.size(), r);
                    clear_collection();
                end
            end
            default: begin
                // spare op: no result, no state change
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic link_in_t rand_noise();
        logic [31:0] r0;
        logic [31:0] r1;
        link_in_t    it;
        r0 = $urandom;
        r1 = $urandom;
        it = {r1[12:0], r0};
        return it;
    endfunction

    function automatic link_in_t req_item(input logic [1:0] op, input logic [6:0] st,
                                          input logic [2:0] kind, input logic [7:0] code,
                                          input logic [15:0] val);
        link_in_t it;
        it          = '0;
        it.op       = op;
        it.station  = st;
        it.reg_kind = kind;
        it.code     = code;
        it.value    = val;
        return it;
    endfunction

    function automatic link_in_t reply_item(input logic [7:0] b, input logic lst);
        link_in_t it;
        it         = '0;
        it.op      = OP_REPLY;
        it.rx      = b;
        it.rx_last = lst;
        return it;
    endfunction

    function automatic link_out_t reply_verdict(input logic [1:0] st, input logic [15:0] pv,
                                                input logic [15:0] sv, input logic [15:0] mv,
                                                input logic [15:0] aux);
        link_out_t r;
        r        = '0;
        r.kind   = KIND_REPLY;
        r.last   = 1'b1;
        r.status = st;
        r.words  = {aux, mv, sv, pv};
        return r;
    endfunction

    function automatic void add_row(input link_in_t it, input bit typed = 1'b0,
                                    input link_out_t want = '0);
        stim_row_t row;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // random request; fields it ignores stay random
    function automatic link_in_t rand_request();
        link_in_t it;
        it    = rand_noise();
        it.op = ($urandom_range(1) != 0) ? OP_WRITE : OP_READ;
        if ($urandom_range(99) < 70)
            it.reg_kind = REG_KIND_PARAM;
        gen_station = it.station;
        return it;
    endfunction

    // Offers one item, with random idle cycles first, and waits for the handshake.
    // Prediction happens at the accepting edge.
    task automatic send_item(input link_in_t it, input bit typed = 1'b0,
                             input link_out_t want = '0);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tlast  <= it.rx_last;
        s_axis_tdata  <= {6'd0, it.rx, it.value, it.code, it.reg_kind, it.station};
        do @(posedge aclk); while (!s_axis_tready);
        build_frame_or_verdict(it);
        if (typed)
            frame_verdict_q.insert(frame_verdict_q.size(), want);
        else
            foreach (step_out[i]) frame_verdict_q.insert(frame_verdict_q.size(), step_out[i]);
        if (it.op != OP_SPARE)
            items_sent++;
    endtask

    // Reply of n bytes: random words, then a checksum for the last requested station
    // in the final two bytes (when n allows). Optionally one bit flipped, optionally
    // left without its last flag so that the next request cuts it off.
    task automatic send_reply(input int n, input bit corrupt, input bit finish);
        logic [7:0]  b [16];
        logic [15:0] sum;
        link_in_t    it;
        int          k;
        int          bi;
        foreach (b[i]) b[i] = 8'($urandom);
        sum = {9'd0, gen_station};
        for (k = 0; k < 4; k++)
            sum = sum + {b[2*k+1], b[2*k]};
        if (n >= 10) begin
            b[n-2] = sum[7:0];
            b[n-1] = sum[15:8];
        end
        if (corrupt) begin
            k        = $urandom_range(n - 1);
            bi       = $urandom_range(7);
            b[k][bi] = ~b[k][bi];
        end
        for (k = 0; k < n; k++) begin
            // junk in the fields a reply byte does not use
            it         = rand_noise();
            it.op      = OP_REPLY;
            it.rx      = b[k];
            it.rx_last = finish && (k == n - 1);
            send_item(it);
        end
    endtask

    // ---------------------------------------------------------------- sender

    initial begin : stimulus
        int       goal;
        int       pick;
        int       shape;
        link_in_t it;

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_READ;
        s_axis_tlast  = 1'b0;
        kept_station  = '0;
        clear_collection();

        // directed rows
        // reply byte straight after reset: too short, words zero
        add_row(reply_item(8'h00, 1'b1), 1'b1,
                reply_verdict(ST_SHORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        add_row(req_item(OP_READ, 7'd0, REG_KIND_PARAM, 8'h00, 16'h0000));
        // all-ones write: checksum wraps
        add_row(req_item(OP_WRITE, 7'd127, REG_KIND_PARAM, 8'hFF, 16'hFFFF));
        // stray reply byte, then a new request must throw it away
        add_row(reply_item(8'h5A, 1'b0));
        // non-parameter kind: code and (for a read) value dropped
        add_row(req_item(OP_READ, 7'd127, REG_KIND_UNUSED, 8'h55, 16'hBEEF));
        // all-ones reply for station 127: 4*ffff + 7f = 0x007b, good
        for (int i = 0; i < 8; i++) add_row(reply_item(8'hFF, 1'b0));
        add_row(reply_item(8'h7B, 1'b0));
        add_row(reply_item(8'h00, 1'b1), 1'b1,
                reply_verdict(ST_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // spare op with every field set: ignored
        add_row('1);
        add_row(req_item(OP_WRITE, 7'h15, REG_KIND_SV, 8'h12, 16'h1234));
        // eleven zero bytes: long reply, sum 0x15 against 0 -> bad checksum
        for (int i = 0; i < 10; i++) add_row(reply_item(8'h00, 1'b0));
        add_row(reply_item(8'h00, 1'b1), 1'b1,
                reply_verdict(ST_BAD_SUM, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);

        // random phases: none, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase
            if (ph == 0) begin
                // receiver holds off while requests keep coming: block fills up
                hold_off_req = 1'b1;
                for (int k = 0; k < 6; k++) send_item(rand_request());
            end
            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // request followed by a reply of some shape
                    send_item(rand_request());
                    shape = $urandom_range(99);
                    if (shape < 55)
                        send_reply(10, 1'b0, 1'b1);
                    else if (shape < 67)
                        send_reply($urandom_range(14, 11), 1'b0, 1'b1);
                    else if (shape < 77)
                        send_reply($urandom_range(9, 1), 1'b0, 1'b1);
                    else if (shape < 89)
                        send_reply($urandom_range(12, 10), 1'b1, 1'b1);
                    else
                        send_reply($urandom_range(9, 1), 1'b0, 1'b0);
                end else if (pick < 85) begin
                    send_reply($urandom_range(12, 1), 1'b0, 1'b1);
                end else if (pick < 93) begin
                    send_item(rand_request());
                end else begin
                    it    = rand_noise();
                    it.op = OP_SPARE;
                    send_item(it);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (frame_verdict_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && frame_verdict_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    initial begin : result_side
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge aclk) begin : result_check
        link_out_t got;
        link_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.kind     = m_axis_tuser;
            got.tx       = m_axis_tdata[7:0];
            got.last     = m_axis_tlast;
            got.status   = m_axis_tdata[9:8];
            got.words[0] = m_axis_tdata[25:10];
            got.words[1] = m_axis_tdata[41:26];
            got.words[2] = m_axis_tdata[57:42];
            got.words[3] = m_axis_tdata[73:58];
            if (frame_verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result item with nothing awaited: kind %0d tx %02h st %0d",
                             $time, got.kind, got.tx, got.status);
            end else begin
                want = frame_verdict_q.pop_front();
                if (got.kind != want.kind || got.tx != want.tx || got.last != want.last
                    || got.status != want.status || got.words[0] != want.words[0]
                    || got.words[1] != want.words[1] || got.words[2] != want.words[2]
                    || got.words[3] != want.words[3]) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t: mismatch exp kind %0d tx %02h last %0d st %0d ",
                                  "w %04h %04h %04h %04h, got kind %0d tx %02h last %0d ",
                                  "st %0d w %04h %04h %04h %04h"},
                                 $time, want.kind, want.tx, want.last, want.status,
                                 want.words[0], want.words[1], want.words[2], want.words[3],
                                 got.kind, got.tx, got.last, got.status,
                                 got.words[0], got.words[1], got.words[2], got.words[3]);
                end
            end
        end
    end

    // hard stop
    initial begin
        #(12 * 400000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
